>>> sv/tsim_pkg.sv
// Shared types and constants of the tensor slice index map unit.
`timescale 1ns / 1ps
package tsim_pkg;

  localparam int unsigned MaxDims   = 4;
  localparam int unsigned ExtW      = 16;
  localparam int unsigned IdxW      = 32;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned RankW     = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned StrW      = 48;
  localparam int unsigned DvsW      = IdxW + 1;
  localparam int unsigned DivBits   = 4;
  localparam int unsigned DivStages = IdxW / DivBits;

  localparam logic [DvsW-1:0] IdxLimit = {1'b1, {IdxW{1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANK      = 3'd0,
    CFG_IN_SHAPE  = 3'd1,
    CFG_OUT_SHAPE = 3'd2,
    CFG_START     = 3'd3,
    CFG_STEP      = 3'd4
  } cfg_idx_e;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [MaxDims-1:0]             used;
    logic [MaxDims-1:0][DvsW-1:0]   dvs;
    logic [MaxDims-1:0][StrW-1:0]   istr;
    logic [DvsW-1:0]                out_size;
    logic [DvsW-1:0]                in_size;
    logic [MaxDims-1:0][ExtW-1:0]   start;
    logic [MaxDims-1:0][ExtW-1:0]   step;
  } drv_t;

  // One item on its way through the division stages.
  typedef struct packed {
    logic [IdxW-1:0]              oidx;
    logic [IdxW-1:0]              rem;
    logic [IdxW-1:0]              pr;
    logic [MaxDims-1:0][IdxW-1:0] coord;
  } item_t;

endpackage

>>> sv/tsim_cfg.sv
// Configuration registers and the pipelined derivation of strides and sizes.
`timescale 1ns / 1ps
module tsim_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsim_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsim_pkg::CfgW-1:0]         cfg_wdata_i,
  output tsim_pkg::drv_t                    drv_o
);

  localparam int unsigned ND = tsim_pkg::MaxDims;
  localparam int unsigned EW = tsim_pkg::ExtW;
  localparam int unsigned SW = tsim_pkg::StrW;
  localparam int unsigned VW = tsim_pkg::DvsW;

  logic [tsim_pkg::RankW-1:0] rank_q;
  logic [tsim_pkg::CfgW-1:0]  in_shape_q, out_shape_q, start_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q      <= tsim_pkg::RankW'(1);
      in_shape_q  <= '0;
      out_shape_q <= '0;
      start_q     <= '0;
      step_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (tsim_pkg::cfg_idx_e'(cfg_idx_i))
        tsim_pkg::CFG_RANK:      rank_q      <= cfg_wdata_i[tsim_pkg::RankW-1:0];
        tsim_pkg::CFG_IN_SHAPE:  in_shape_q  <= cfg_wdata_i;
        tsim_pkg::CFG_OUT_SHAPE: out_shape_q <= cfg_wdata_i;
        tsim_pkg::CFG_START:     start_q     <= cfg_wdata_i;
        tsim_pkg::CFG_STEP:      step_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [tsim_pkg::RankW-1:0] ru;
  logic [ND-1:0]              used;
  logic [ND-1:0][EW-1:0]      oe, ie;

  // Extents of dimensions beyond the rank count as one.
  always_comb begin
    priority if (rank_q == '0) begin
      ru = tsim_pkg::RankW'(1);
    end else if (rank_q > tsim_pkg::RankW'(ND)) begin
      ru = tsim_pkg::RankW'(ND);
    end else begin
      ru = rank_q;
    end
    for (int d = 0; d < ND; d++) begin
      used[d] = tsim_pkg::RankW'(d) < ru;
      oe[d]   = used[d] ? out_shape_q[EW*d +: EW] : EW'(1);
      ie[d]   = used[d] ? in_shape_q[EW*d +: EW] : EW'(1);
    end
  end

  // First step: pair products of the two innermost extents.
  logic [ND-1:0]         used1_q;
  logic [ND-1:0][EW-1:0] oe1_q, ie1_q;
  logic [2*EW-1:0]       o23_q, i23_q;

  always_ff @(posedge clk_i) begin
    used1_q <= used;
    oe1_q   <= oe;
    ie1_q   <= ie;
    o23_q   <= {{EW{1'b0}}, oe[2]} * {{EW{1'b0}}, oe[3]};
    i23_q   <= {{EW{1'b0}}, ie[2]} * {{EW{1'b0}}, ie[3]};
  end

  // Second step: row-major strides.
  logic [ND-1:0]         used2_q;
  logic [EW-1:0]         oe0_2_q, ie0_2_q;
  logic [ND-1:0][SW-1:0] os2_q, is2_q;

  always_ff @(posedge clk_i) begin
    used2_q  <= used1_q;
    oe0_2_q  <= oe1_q[0];
    ie0_2_q  <= ie1_q[0];
    os2_q[3] <= SW'(1);
    is2_q[3] <= SW'(1);
    os2_q[2] <= {{(SW-EW){1'b0}}, oe1_q[3]};
    is2_q[2] <= {{(SW-EW){1'b0}}, ie1_q[3]};
    os2_q[1] <= {{(SW-2*EW){1'b0}}, o23_q};
    is2_q[1] <= {{(SW-2*EW){1'b0}}, i23_q};
    os2_q[0] <= {{(SW-EW){1'b0}}, oe1_q[1]} * {{(SW-2*EW){1'b0}}, o23_q};
    is2_q[0] <= {{(SW-EW){1'b0}}, ie1_q[1]} * {{(SW-2*EW){1'b0}}, i23_q};
  end

  // Third step: divisors clamped to 33 bits, partial products of the sizes.
  localparam int unsigned HW = SW / 2;
  localparam int unsigned PW = EW + HW;

  logic [ND-1:0]         used3_q;
  logic [ND-1:0][VW-1:0] dvs3_q;
  logic [ND-1:0][SW-1:0] is3_q;
  logic [PW-1:0]         ofh_q, ofl_q, ifh_q, ifl_q;

  always_ff @(posedge clk_i) begin
    used3_q <= used2_q;
    is3_q   <= is2_q;
    for (int d = 0; d < ND; d++) begin
      dvs3_q[d] <= (|os2_q[d][SW-1:VW-1]) ? tsim_pkg::IdxLimit :
                   {1'b0, os2_q[d][VW-2:0]};
    end
    ofh_q <= {{HW{1'b0}}, oe0_2_q} * {{EW{1'b0}}, os2_q[0][SW-1:HW]};
    ofl_q <= {{HW{1'b0}}, oe0_2_q} * {{EW{1'b0}}, os2_q[0][HW-1:0]};
    ifh_q <= {{HW{1'b0}}, ie0_2_q} * {{EW{1'b0}}, is2_q[0][SW-1:HW]};
    ifl_q <= {{HW{1'b0}}, ie0_2_q} * {{EW{1'b0}}, is2_q[0][HW-1:0]};
  end

  // Fourth step: element counts, saturated at 2^32.
  localparam int unsigned FW = EW + SW;

  logic [FW-1:0] ofull, ifull;

  always_comb begin
    ofull = {ofh_q, {HW{1'b0}}} + {{HW{1'b0}}, ofl_q};
    ifull = {ifh_q, {HW{1'b0}}} + {{HW{1'b0}}, ifl_q};
  end

  logic [ND-1:0]         used4_q;
  logic [ND-1:0][VW-1:0] dvs4_q;
  logic [ND-1:0][SW-1:0] is4_q;
  logic [VW-1:0]         osize_q, isize_q;

  always_ff @(posedge clk_i) begin
    used4_q <= used3_q;
    dvs4_q  <= dvs3_q;
    is4_q   <= is3_q;
    osize_q <= (|ofull[FW-1:VW-1]) ? tsim_pkg::IdxLimit : {1'b0, ofull[VW-2:0]};
    isize_q <= (|ifull[FW-1:VW-1]) ? tsim_pkg::IdxLimit : {1'b0, ifull[VW-2:0]};
  end

  always_comb begin
    drv_o.used     = used4_q;
    drv_o.dvs      = dvs4_q;
    drv_o.istr     = is4_q;
    drv_o.out_size = osize_q;
    drv_o.in_size  = isize_q;
    drv_o.start    = start_q;
    drv_o.step     = step_q;
  end

endmodule

>>> sv/tsim_div_stage.sv
// One pipeline stage of the restoring divider: four quotient bits of one dimension.
`timescale 1ns / 1ps
module tsim_div_stage #(
  parameter int unsigned Dim  = 0,
  parameter int unsigned Step = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  tsim_pkg::item_t             item_i,
  input  logic [tsim_pkg::DvsW-1:0]   dvs_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output tsim_pkg::item_t             item_o
);

  localparam int unsigned IW = tsim_pkg::IdxW;
  localparam int unsigned DB = tsim_pkg::DivBits;
  localparam int unsigned Hi = IW - 1 - Step * DB;

  tsim_pkg::item_t nxt;
  logic            valid_q;
  tsim_pkg::item_t item_q;

  always_comb begin
    logic [IW-1:0] pr;
    logic [IW:0]   t;
    logic [DB-1:0] bits;
    logic [DB-1:0] q;
    nxt  = item_i;
    pr   = (Step == 0) ? '0 : item_i.pr;
    bits = item_i.rem[Hi -: DB];
    q    = '0;
    for (int j = 0; j < DB; j++) begin
      t    = {pr, bits[DB-1]};
      bits = {bits[DB-2:0], 1'b0};
      // A zero divisor never subtracts, so its coordinate stays zero.
      if ((dvs_i != '0) && (t >= dvs_i)) begin
        pr = IW'(t - dvs_i);
        q  = {q[DB-2:0], 1'b1};
      end else begin
        pr = t[IW-1:0];
        q  = {q[DB-2:0], 1'b0};
      end
    end
    nxt.coord[Dim][Hi -: DB] = q;
    nxt.pr                   = pr;
    if (Step == tsim_pkg::DivStages - 1) begin
      nxt.rem = pr;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> sv/tsim_term.sv
// Term pipeline: start plus coordinate times step, scaling by input stride, range checks.
`timescale 1ns / 1ps
module tsim_term (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  tsim_pkg::item_t             item_i,
  input  tsim_pkg::drv_t              drv_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [tsim_pkg::IdxW-1:0]   in_index_o,
  output logic                        index_invalid_o
);

  localparam int unsigned ND = tsim_pkg::MaxDims;
  localparam int unsigned IW = tsim_pkg::IdxW;
  localparam int unsigned EW = tsim_pkg::ExtW;
  localparam int unsigned SW = tsim_pkg::StrW;
  localparam int unsigned NT = 7;
  localparam int unsigned AW = IW + EW + 2;      // start + coord * step
  localparam int unsigned MW = AW - 1;           // magnitude plus one
  localparam int unsigned ML = 25;
  localparam int unsigned MH = MW - ML;
  localparam int unsigned SL = SW / 2;
  localparam int unsigned S1W = ML + SW + 1;
  localparam int unsigned S2W = MH + SW + 1;
  localparam int unsigned PW = MW + SW;
  localparam int unsigned TLW = 61;              // holds up to 2^60
  localparam int unsigned TW = TLW + 1;
  localparam int unsigned UW = TW + 1;
  localparam int unsigned RW = TW + 2;

  logic [NT-1:0] vld_q;
  logic [NT-1:0] vin;
  logic [NT:0]   rdy;
  logic [NT-1:0] ld;

  assign vin = {vld_q[NT-2:0], valid_i};

  always_comb begin
    rdy[NT] = ready_i;
    for (int k = NT - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ld = rdy[NT-1:0] & vin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NT; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NT-1];

  // Stage 1: signed coordinate transform, output index bound.
  logic [ND-1:0][AW-1:0] a1;
  logic [ND-1:0][AW-1:0] a_q;
  logic                  oob1_q;

  always_comb begin
    logic signed [IW:0]      cs;
    logic signed [EW-1:0]    stp;
    logic signed [AW-2:0]    prod;
    for (int d = 0; d < ND; d++) begin
      cs    = {1'b0, item_i.coord[d]};
      stp   = drv_i.step[d];
      prod  = cs * stp;
      a1[d] = {prod[AW-2], prod} + {{(AW-EW){1'b0}}, drv_i.start[d]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      a_q    <= a1;
      oob1_q <= {1'b0, item_i.oidx} >= drv_i.out_size;
    end
  end

  // Stage 2: partial products of (|a| + 1) times the input stride.
  logic [ND-1:0][ML+SL-1:0] ll, lh;
  logic [ND-1:0][MH+SL-1:0] hl, hh;
  logic [ND-1:0]            neg;
  logic [ND-1:0][ML+SL-1:0] ll_q, lh_q;
  logic [ND-1:0][MH+SL-1:0] hl_q, hh_q;
  logic [ND-1:0]            neg2_q;
  logic                     oob2_q;

  always_comb begin
    logic [AW-1:0] mag;
    logic [MW-1:0] m1;
    for (int d = 0; d < ND; d++) begin
      neg[d] = a_q[d][AW-1];
      mag    = neg[d] ? (~a_q[d] + AW'(1)) : a_q[d];
      m1     = mag[MW-1:0] + MW'(1);
      ll[d]  = {{SL{1'b0}}, m1[ML-1:0]} * {{ML{1'b0}}, drv_i.istr[d][SL-1:0]};
      lh[d]  = {{SL{1'b0}}, m1[ML-1:0]} * {{ML{1'b0}}, drv_i.istr[d][SW-1:SL]};
      hl[d]  = {{SL{1'b0}}, m1[MW-1:ML]} * {{MH{1'b0}}, drv_i.istr[d][SL-1:0]};
      hh[d]  = {{SL{1'b0}}, m1[MW-1:ML]} * {{MH{1'b0}}, drv_i.istr[d][SW-1:SL]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      ll_q   <= ll;
      lh_q   <= lh;
      hl_q   <= hl;
      hh_q   <= hh;
      neg2_q <= neg;
      oob2_q <= oob1_q;
    end
  end

  // Stage 3: first half of the partial product sum.
  logic [ND-1:0][S1W-1:0] s1_q;
  logic [ND-1:0][S2W-1:0] s2_q;
  logic [ND-1:0]          neg3_q;
  logic                   oob3_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int d = 0; d < ND; d++) begin
        s1_q[d] <= {{(S1W-ML-SL){1'b0}}, ll_q[d]} + {1'b0, lh_q[d], {SL{1'b0}}};
        s2_q[d] <= {{(S2W-MH-SL){1'b0}}, hl_q[d]} + {1'b0, hh_q[d], {SL{1'b0}}};
      end
      neg3_q <= neg2_q;
      oob3_q <= oob2_q;
    end
  end

  // Stage 4: full product and the term limit test.
  logic [ND-1:0][TLW-1:0] pl4_q;
  logic [ND-1:0]          over4_q;
  logic [ND-1:0]          neg4_q;
  logic                   oob4_q;

  always_ff @(posedge clk_i) begin
    logic [PW-1:0] p;
    if (ld[3]) begin
      for (int d = 0; d < ND; d++) begin
        p = {{(PW-S1W){1'b0}}, s1_q[d]} + {s2_q[d][S2W-2:0], {ML{1'b0}}};
        // Over the limit when (|a| + 1) * stride exceeds 2^60.
        over4_q[d] <= (|p[PW-1:TLW]) || (p[TLW-1] && (|p[TLW-2:0]));
        pl4_q[d]   <= p[TLW-1:0];
      end
      neg4_q <= neg3_q;
      oob4_q <= oob3_q;
    end
  end

  // Stage 5: signed term, skipped dimensions contribute nothing.
  logic [ND-1:0][TW-1:0] term5_q;
  logic                  bad5_q;

  always_ff @(posedge clk_i) begin
    logic [TLW-1:0] tm;
    if (ld[4]) begin
      for (int d = 0; d < ND; d++) begin
        tm = pl4_q[d] - {{(TLW-SW){1'b0}}, drv_i.istr[d]};
        if (!drv_i.used[d] || over4_q[d]) begin
          term5_q[d] <= '0;
        end else begin
          term5_q[d] <= neg4_q[d] ? (TW'(0) - {1'b0, tm}) : {1'b0, tm};
        end
      end
      bad5_q <= oob4_q || (|(drv_i.used & over4_q));
    end
  end

  // Stage 6: pairwise sums.
  logic [UW-1:0] s01_q, s23_q;
  logic          bad6_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s01_q  <= {term5_q[0][TW-1], term5_q[0]} + {term5_q[1][TW-1], term5_q[1]};
      s23_q  <= {term5_q[2][TW-1], term5_q[2]} + {term5_q[3][TW-1], term5_q[3]};
      bad6_q <= bad5_q;
    end
  end

  // Stage 7: final sum and source range check; this is the output register.
  logic [RW-1:0] sum;
  logic          inv;
  logic [IW-1:0] idx_q;
  logic          inv_q;

  always_comb begin
    sum = {s01_q[UW-1], s01_q} + {s23_q[UW-1], s23_q};
    inv = bad6_q || sum[RW-1] ||
          (sum >= {{(RW-tsim_pkg::DvsW){1'b0}}, drv_i.in_size});
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      idx_q <= inv ? '0 : sum[IW-1:0];
      inv_q <= inv;
    end
  end

  assign in_index_o      = idx_q;
  assign index_invalid_o = inv_q;

endmodule

>>> sv/tensor_slice_index_map_unit.sv
// Top level of the tensor slice index map unit: input stages, divider chain, term pipeline.
//
// The block turns the row-major flat index of an element of a strided slice
// (out_index_i) into the flat index of its source element in the input tensor
// (in_index_o), with index_invalid_o set when that address cannot be used.
// Both channels move a transfer at a rising edge where valid is high and stall
// is low. The configuration port writes one register per cycle with cfg_we_i;
// the user must write it only while no item is in flight; the block itself
// does not enforce this. One item enters and one result leaves per cycle
// while the receiver does not stall. The pipeline has four input stages
// while derived strides settle after a write, 32 divider stages (four
// quotient bits per stage, eight stages per dimension), and seven stages of
// multiply, sum and range check. When the receiver stalls, each stage holds
// its item and empty stages still fill, so items are accepted until the
// pipeline is full; nothing is lost or repeated. Reset empties the pipeline,
// sets rank to one and clears the other configuration registers.
`timescale 1ns / 1ps
module tensor_slice_index_map_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsim_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tsim_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tsim_pkg::IdxW-1:0]         out_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tsim_pkg::IdxW-1:0]         in_index_o,
  output logic                              index_invalid_o
);

  localparam int unsigned Pre  = 4;
  localparam int unsigned NDiv = tsim_pkg::MaxDims * tsim_pkg::DivStages;
  localparam int unsigned Last = Pre + NDiv;

  tsim_pkg::drv_t  drv;
  tsim_pkg::item_t node_d [Last+1];
  logic            node_v [Last+1];
  logic            node_r [Last+1];

  tsim_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .drv_o       (drv)
  );

  always_comb begin
    node_d[0]       = '0;
    node_d[0].oidx  = out_index_i;
    node_d[0].rem   = out_index_i;
    node_v[0]       = in_valid_i;
  end

  assign in_stall_o = !node_r[0];

  // Input stages carry the item while the derived strides catch up.
  for (genvar k = 0; k < Pre; k++) begin : g_pre
    logic            v_q;
    tsim_pkg::item_t d_q;

    assign node_r[k] = !v_q || node_r[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (node_r[k]) begin
        v_q <= node_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (node_r[k] && node_v[k]) begin
        d_q <= node_d[k];
      end
    end

    assign node_v[k+1] = v_q;
    assign node_d[k+1] = d_q;
  end

  for (genvar d = 0; d < tsim_pkg::MaxDims; d++) begin : g_dim
    for (genvar s = 0; s < tsim_pkg::DivStages; s++) begin : g_step
      localparam int unsigned N = Pre + d * tsim_pkg::DivStages + s;

      tsim_div_stage #(
        .Dim  (d),
        .Step (s)
      ) u_div (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (node_v[N]),
        .ready_o (node_r[N]),
        .item_i  (node_d[N]),
        .dvs_i   (drv.dvs[d]),
        .valid_o (node_v[N+1]),
        .ready_i (node_r[N+1]),
        .item_o  (node_d[N+1])
      );
    end
  end

  tsim_term u_term (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (node_v[Last]),
    .ready_o         (node_r[Last]),
    .item_i          (node_d[Last]),
    .drv_i           (drv),
    .valid_o         (out_valid_o),
    .ready_i         (!out_stall_i),
    .in_index_o      (in_index_o),
    .index_invalid_o (index_invalid_o)
  );

endmodule
